FILE: hw/rtl/tshs_pkg.sv
`default_nettype none
package tshs_pkg;

	localparam int unsigned SPEED_TABLE_LEN = 10;
	localparam int unsigned MOTOR_COUNT     = 3;
	localparam int unsigned MOTOR_SLOTS     = 3;

	localparam int unsigned CMD_W   = 2;
	localparam int unsigned SEL_W   = 2;
	localparam int unsigned STEP_W  = 32;
	localparam int unsigned SLOT_W  = 4;
	localparam int unsigned TICKS_W = 8;
	localparam int unsigned WAIT_W  = 9;
	localparam int unsigned PHASE_W = 4;
	localparam int unsigned NIB_W   = 4;
	localparam int unsigned BYTE_W  = 8;

	localparam logic [PHASE_W-1:0] PHASE_LAST = 4'd7;
	localparam logic [PHASE_W-1:0] PHASE_OFF  = 4'd8;
	localparam logic [WAIT_W-1:0]  WAIT_IDLE  = 9'h1FF;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK  = 2'd0,
		CMD_START = 2'd1,
		CMD_WRITE = 2'd2
	} cmd_t;

	// apb register indexes
	typedef enum logic [0:0] {
		REG_IR_ENABLE = 1'b0
	} reg_idx_t;

	// half-step coil pattern, low-nibble form (high nibble is the same shifted by four)
	localparam logic [NIB_W-1:0] COIL_PATTERN [9] = '{
		4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9, 4'h0
	};

	typedef struct packed {
		logic                  tick;
		logic                  start;
		logic                  write;
		logic [STEP_W-1:0]     step_total;
		logic                  clockwise;
		logic [SLOT_W-1:0]     slot;
		logic [TICKS_W-1:0]    wait_ticks;
	} motor_cmd_t;

	function automatic logic [NIB_W-1:0] coil_nibble(input logic [PHASE_W-1:0] phase);
		logic [NIB_W-1:0] nib;
		nib = 4'h0;
		if (phase <= PHASE_OFF) begin
			nib = COIL_PATTERN[phase];
		end
		return nib;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/tshs_motor.sv
`default_nettype none
module tshs_motor #(
	parameter int unsigned SpeedTableLen = tshs_pkg::SPEED_TABLE_LEN
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  tshs_pkg::motor_cmd_t              mcmd,
	output logic [tshs_pkg::NIB_W-1:0]        coil_next
);

	localparam int unsigned IdxW = (SpeedTableLen > 1) ? $clog2(SpeedTableLen) : 1;
	localparam logic [IdxW-1:0] PtrLast = IdxW'(SpeedTableLen - 1);
	localparam logic [tshs_pkg::SLOT_W:0] SlotLimit = (tshs_pkg::SLOT_W + 1)'(SpeedTableLen);

	logic [tshs_pkg::STEP_W-1:0]  steps_q, steps_n;
	logic                         running_q, running_n;
	logic                         dir_q, dir_n;
	logic [tshs_pkg::PHASE_W-1:0] phase_q, phase_n, phase_step;
	logic [tshs_pkg::WAIT_W-1:0]  wait_q, wait_n;
	logic [IdxW-1:0]              ptr_q, ptr_n;
	logic [tshs_pkg::TICKS_W-1:0] speed_q [SpeedTableLen];
	logic                         slot_ok;

	assign slot_ok = {1'b0, mcmd.slot} < SlotLimit;

	always_comb begin
		if (dir_q) begin
			phase_step = (phase_q >= tshs_pkg::PHASE_LAST) ? '0 : phase_q + 1'b1;
		end else begin
			phase_step = (phase_q == '0) ? tshs_pkg::PHASE_LAST : phase_q - 1'b1;
		end
	end

	always_comb begin
		steps_n   = steps_q;
		running_n = running_q;
		dir_n     = dir_q;
		phase_n   = phase_q;
		wait_n    = wait_q;
		ptr_n     = ptr_q;
		if (mcmd.tick) begin
			if (steps_q > tshs_pkg::STEP_W'(1)) begin
				if (wait_q == '0) begin
					phase_n = phase_step;
					steps_n = steps_q - 1'b1;
					wait_n  = {1'b0, speed_q[ptr_q]};
					ptr_n   = (ptr_q == PtrLast) ? '0 : ptr_q + 1'b1;
				end else begin
					wait_n = wait_q - 1'b1;
				end
			end else begin
				steps_n   = '0;
				running_n = 1'b0;
				wait_n    = tshs_pkg::WAIT_IDLE;
			end
			if (!running_n) begin
				phase_n = tshs_pkg::PHASE_OFF;
			end
		end else if (mcmd.start) begin
			steps_n   = mcmd.step_total;
			dir_n     = mcmd.clockwise;
			running_n = 1'b1;
			wait_n    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q   <= '0;
			running_q <= 1'b0;
			dir_q     <= 1'b0;
			phase_q   <= '0;
			wait_q    <= '0;
			ptr_q     <= '0;
		end else begin
			steps_q   <= steps_n;
			running_q <= running_n;
			dir_q     <= dir_n;
			phase_q   <= phase_n;
			wait_q    <= wait_n;
			ptr_q     <= ptr_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SpeedTableLen; i++) begin
				speed_q[i] <= '0;
			end
		end else if (mcmd.write && slot_ok) begin
			speed_q[mcmd.slot[IdxW-1:0]] <= mcmd.wait_ticks;
		end
	end

	assign coil_next = tshs_pkg::coil_nibble(phase_n);

endmodule
`default_nettype wire

FILE: hw/rtl/three_stepper_halfstep_scheduler.sv
// path: an accepted transaction goes from the input stage register to the result register
// throughput: one transaction per cycle unless a held result stalls input; every command,
// tick included, passes once through the per-motor update logic between those registers
// reset: arst_n clears all motor state, speed tables, last shifted bytes and ir enable
`default_nettype none
module three_stepper_halfstep_scheduler #(
	parameter int unsigned SpeedTableLen = tshs_pkg::SPEED_TABLE_LEN,
	parameter int unsigned MotorCount    = tshs_pkg::MOTOR_COUNT
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  psel,
	input  wire                                  penable,
	input  wire                                  pwrite,
	input  wire  [2:0]                           paddr,
	input  wire  [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	input  wire                                  item_valid,
	output logic                                 item_stall,
	input  wire  [tshs_pkg::CMD_W-1:0]           cmd,
	input  wire  [tshs_pkg::SEL_W-1:0]           motor_sel,
	input  wire  [tshs_pkg::STEP_W-1:0]          step_total,
	input  wire                                  clockwise,
	input  wire  [tshs_pkg::SLOT_W-1:0]          table_slot,
	input  wire  [tshs_pkg::TICKS_W-1:0]         wait_ticks,
	output logic                                 result_valid,
	input  wire                                  result_stall,
	output logic [tshs_pkg::BYTE_W-1:0]          shift_byte_low,
	output logic [tshs_pkg::BYTE_W-1:0]          shift_byte_high,
	output logic                                 bytes_changed
);

	// config register
	logic ir_enable_q;
	logic reg_hit;

	assign reg_hit = paddr[2] == tshs_pkg::REG_IR_ENABLE;
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? {31'b0, ir_enable_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ir_enable_q <= 1'b0;
		end else if (psel && penable && pwrite && reg_hit) begin
			ir_enable_q <= pwdata[0];
		end
	end

	// input stage
	logic                           s1_valid_q;
	logic [tshs_pkg::CMD_W-1:0]     cmd_s1;
	logic [tshs_pkg::SEL_W-1:0]     sel_s1;
	logic [tshs_pkg::STEP_W-1:0]    steps_s1;
	logic                           cw_s1;
	logic [tshs_pkg::SLOT_W-1:0]    slot_s1;
	logic [tshs_pkg::TICKS_W-1:0]   ticks_s1;
	logic                           s1_go;
	logic                           item_take;
	logic                           is_tick;
	logic                           result_valid_q;

	assign s1_go      = s1_valid_q && (!result_valid_q || !result_stall);
	assign item_stall = s1_valid_q && !s1_go;
	assign item_take  = item_valid && !item_stall;
	assign is_tick    = cmd_s1 == tshs_pkg::CMD_TICK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (item_take) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			cmd_s1   <= cmd;
			sel_s1   <= motor_sel;
			steps_s1 <= step_total;
			cw_s1    <= clockwise;
			slot_s1  <= table_slot;
			ticks_s1 <= wait_ticks;
		end
	end

	// motors
	logic [tshs_pkg::NIB_W-1:0] coil_nib [tshs_pkg::MOTOR_SLOTS];

	for (genvar g = 0; g < tshs_pkg::MOTOR_SLOTS; g++) begin : g_motor
		if (g < MotorCount) begin : g_on
			tshs_pkg::motor_cmd_t mcmd;
			logic                 hit;

			assign hit              = sel_s1 == tshs_pkg::SEL_W'(g);
			assign mcmd.tick        = s1_go && is_tick;
			assign mcmd.start       = s1_go && hit && (cmd_s1 == tshs_pkg::CMD_START);
			assign mcmd.write       = s1_go && hit && (cmd_s1 == tshs_pkg::CMD_WRITE);
			assign mcmd.step_total  = steps_s1;
			assign mcmd.clockwise   = cw_s1;
			assign mcmd.slot        = slot_s1;
			assign mcmd.wait_ticks  = ticks_s1;

			tshs_motor #(
				.SpeedTableLen(SpeedTableLen)
			) u_motor (
				.clk      (clk),
				.arst_n   (arst_n),
				.mcmd     (mcmd),
				.coil_next(coil_nib[g])
			);
		end else begin : g_off
			assign coil_nib[g] = '0;
		end
	end

	// result register
	logic [tshs_pkg::BYTE_W-1:0]   result_low_q, result_high_q;
	logic                          result_changed_q;
	logic [2*tshs_pkg::BYTE_W-1:0] prev_q;
	logic [tshs_pkg::BYTE_W-1:0]   low_new, high_new;

	assign low_new  = {coil_nib[2], coil_nib[1]};
	assign high_new = {coil_nib[0], ir_enable_q, 3'b000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			prev_q         <= '0;
		end else begin
			if (s1_go) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (s1_go && is_tick) begin
				prev_q <= {high_new, low_new};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			if (is_tick) begin
				result_low_q     <= low_new;
				result_high_q    <= high_new;
				result_changed_q <= {high_new, low_new} != prev_q;
			end else begin
				result_low_q     <= prev_q[tshs_pkg::BYTE_W-1:0];
				result_high_q    <= prev_q[2*tshs_pkg::BYTE_W-1:tshs_pkg::BYTE_W];
				result_changed_q <= 1'b0;
			end
		end
	end

	assign result_valid    = result_valid_q;
	assign shift_byte_low  = result_low_q;
	assign shift_byte_high = result_high_q;
	assign bytes_changed   = result_changed_q;

	// the shown bytes always match what was last shifted
	a_prev_matches: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> {result_high_q, result_low_q} == prev_q)
		else $error("result bytes differ from last shifted bytes");

	// input stage only blocks while the result register is held full
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (s1_valid_q && result_valid_q && result_stall))
		else $error("input stalled without a held result");

	// a non-tick transaction never reports a change
	a_changed_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && !is_tick) |=> !result_changed_q)
		else $error("change flagged on a non-tick transaction");

	a_high_pad: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> result_high_q[2:0] == 3'b000)
		else $error("unused bits of high byte set");

endmodule
`default_nettype wire

FILE: tb/three_stepper_halfstep_scheduler_test.sv
`default_nettype none
module three_stepper_halfstep_scheduler_test;

	localparam int unsigned TABLE_LEN = tshs_pkg::SPEED_TABLE_LEN;
	localparam int unsigned MOTORS    = tshs_pkg::MOTOR_COUNT;
	localparam int unsigned CYCLE_LIMIT = 400000;

	localparam logic [1:0] SEL_LEFT   = 2'd0;
	localparam logic [1:0] SEL_RIGHT  = 2'd1;
	localparam logic [1:0] SEL_GRIP   = 2'd2;
	localparam logic [1:0] SEL_NONE   = 2'd3;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [2:0] IR_ENABLE_ADDR = 3'(4 * tshs_pkg::REG_IR_ENABLE);

	typedef struct packed {
		logic [1:0]  cmd;
		logic [1:0]  sel;
		logic [31:0] steps;
		logic        cw;
		logic [3:0]  slot;
		logic [7:0]  ticks;
	} motor_item_t;

	typedef struct packed {
		logic [7:0] lo;
		logic [7:0] hi;
		logic       changed;
	} shift_bytes_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid;
	logic        item_stall;
	logic [1:0]  cmd;
	logic [1:0]  motor_sel;
	logic [31:0] step_total;
	logic        clockwise;
	logic [3:0]  table_slot;
	logic [7:0]  wait_ticks;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [7:0]  shift_byte_low;
	logic [7:0]  shift_byte_high;
	logic        bytes_changed;

	three_stepper_halfstep_scheduler dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.cmd            (cmd),
		.motor_sel      (motor_sel),
		.step_total     (step_total),
		.clockwise      (clockwise),
		.table_slot     (table_slot),
		.wait_ticks     (wait_ticks),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.shift_byte_low (shift_byte_low),
		.shift_byte_high(shift_byte_high),
		.bytes_changed  (bytes_changed)
	);

	// scheduler state mirror
	logic [31:0] steps_left [3];
	logic        running    [3];
	logic        cw_dir     [3];
	logic [3:0]  phase      [3];
	logic [8:0]  wait_cnt   [3];
	logic [3:0]  slot_ptr   [3];
	logic [7:0]  speed      [3][TABLE_LEN];
	logic [15:0] last_bytes;
	logic        ir_on;

	shift_bytes_t expected_bytes [$];
	shift_bytes_t want;
	int unsigned  errors;
	int unsigned  cycles;
	int unsigned  rx_hold;
	bit           tx_gaps_on;
	bit           rx_stalls_on;

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("[%0d] mismatch: %s", cycles, what);
		errors++;
	endtask

	function automatic logic [3:0] coil_nibble_of(input logic [3:0] ph);
		case (ph)
			4'd0: return 4'h1;
			4'd1: return 4'h3;
			4'd2: return 4'h2;
			4'd3: return 4'h6;
			4'd4: return 4'h4;
			4'd5: return 4'hC;
			4'd6: return 4'h8;
			4'd7: return 4'h9;
			default: return 4'h0;
		endcase
	endfunction

	task automatic clear_scheduler_state();
		for (int m = 0; m < 3; m++) begin
			steps_left[m] = '0;
			running[m]    = 1'b0;
			cw_dir[m]     = 1'b0;
			phase[m]      = '0;
			wait_cnt[m]   = '0;
			slot_ptr[m]   = '0;
			for (int s = 0; s < TABLE_LEN; s++) begin
				speed[m][s] = '0;
			end
		end
		last_bytes = '0;
		ir_on      = 1'b0;
	endtask

	function automatic shift_bytes_t advance_scheduler(input motor_item_t it);
		shift_bytes_t r;
		logic [15:0]  now;
		int unsigned  p;
		if (it.cmd != tshs_pkg::CMD_TICK) begin
			if (it.cmd == tshs_pkg::CMD_START && it.sel < MOTORS) begin
				steps_left[it.sel] = it.steps;
				cw_dir[it.sel]     = it.cw;
				running[it.sel]    = 1'b1;
				wait_cnt[it.sel]   = '0;
			end else if (it.cmd == tshs_pkg::CMD_WRITE && it.sel < MOTORS
					&& it.slot < TABLE_LEN) begin
				speed[it.sel][it.slot] = it.ticks;
			end
			r.lo      = last_bytes[7:0];
			r.hi      = last_bytes[15:8];
			r.changed = 1'b0;
			return r;
		end
		for (int m = 0; m < MOTORS; m++) begin
			if (steps_left[m] > 1) begin
				if (wait_cnt[m] == 0) begin
					if (cw_dir[m]) begin
						phase[m] = (phase[m] >= tshs_pkg::PHASE_LAST) ? 4'd0 : phase[m] + 4'd1;
					end else begin
						phase[m] = (phase[m] == 0) ? tshs_pkg::PHASE_LAST : phase[m] - 4'd1;
					end
					steps_left[m] = steps_left[m] - 1;
					p = slot_ptr[m];
					if (p >= TABLE_LEN) begin
						p = 0;
					end
					wait_cnt[m] = {1'b0, speed[m][p]};
					p++;
					if (p >= TABLE_LEN) begin
						p = 0;
					end
					slot_ptr[m] = 4'(p);
				end else begin
					wait_cnt[m] = wait_cnt[m] - 9'd1;
				end
			end else begin
				steps_left[m] = '0;
				running[m]    = 1'b0;
				phase[m]      = tshs_pkg::PHASE_OFF;
				wait_cnt[m]   = tshs_pkg::WAIT_IDLE;
			end
			if (!running[m]) begin
				phase[m] = tshs_pkg::PHASE_OFF;
			end
		end
		// motors beyond the configured count keep their coils released
		r.lo      = {coil_nibble_of(MOTORS > 2 ? phase[2] : tshs_pkg::PHASE_OFF),
			coil_nibble_of(MOTORS > 1 ? phase[1] : tshs_pkg::PHASE_OFF)};
		r.hi      = {coil_nibble_of(phase[0]), ir_on, 3'b000};
		now       = {r.hi, r.lo};
		r.changed = (now != last_bytes);
		last_bytes = now;
		return r;
	endfunction

	// result side: check each transaction, then hold off for a random stretch while rx_stalls_on is set
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch("result with nothing pending");
				end else begin
					want = expected_bytes.pop_front();
					if (shift_byte_low !== want.lo) begin
						report_mismatch($sformatf("shift_byte_low got %h want %h",
							shift_byte_low, want.lo));
					end
					if (shift_byte_high !== want.hi) begin
						report_mismatch($sformatf("shift_byte_high got %h want %h",
							shift_byte_high, want.hi));
					end
					if (bytes_changed !== want.changed) begin
						report_mismatch($sformatf("bytes_changed got %b want %b",
							bytes_changed, want.changed));
					end
				end
				rx_hold = rx_stalls_on ? $urandom_range(0, 15) : 0;
			end
			if (rx_hold != 0) begin
				result_stall <= 1'b1;
				rx_hold--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	function automatic motor_item_t make_item(input logic [1:0] c, input logic [1:0] s,
			input logic [31:0] n, input logic d, input logic [3:0] sl, input logic [7:0] t);
		motor_item_t it;
		it.cmd   = c;
		it.sel   = s;
		it.steps = n;
		it.cw    = d;
		it.slot  = sl;
		it.ticks = t;
		return it;
	endfunction

	task automatic send_item(input motor_item_t it);
		int unsigned gap;
		gap = tx_gaps_on ? $urandom_range(0, 15) : 0;
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		cmd        <= it.cmd;
		motor_sel  <= it.sel;
		step_total <= it.steps;
		clockwise  <= it.cw;
		table_slot <= it.slot;
		wait_ticks <= it.ticks;
		do @(posedge clk); while (item_stall);
		expected_bytes.push_back(advance_scheduler(it));
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
	endtask

	task automatic apb_access(input bit wr, input logic [31:0] data, output logic [31:0] rd);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= IR_ENABLE_ADDR;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
	endtask

	// only called with the scheduler idle
	task automatic set_ir_enable(input logic value);
		logic [31:0] rd;
		apb_access(1'b1, {31'b0, value}, rd);
		ir_on = value;
		apb_access(1'b0, '0, rd);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (rd[0] !== ir_on) begin
			report_mismatch($sformatf("ir enable read back %b want %b", rd[0], ir_on));
		end
	endtask

	function automatic motor_item_t random_item();
		motor_item_t it;
		int unsigned pick;
		it.cmd   = tshs_pkg::CMD_TICK;
		it.sel   = ($urandom_range(0, 19) == 0) ? SEL_NONE : 2'($urandom_range(0, 2));
		it.steps = $urandom();
		it.cw    = 1'($urandom_range(0, 1));
		it.slot  = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
			: 4'($urandom_range(0, TABLE_LEN - 1));
		it.ticks = 8'($urandom());
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			it.cmd = tshs_pkg::CMD_TICK;
		end else if (pick < 72) begin
			it.cmd = tshs_pkg::CMD_START;
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				it.steps = $urandom_range(0, 30);
			end else if (pick < 9) begin
				it.steps = $urandom_range(0, 300);
			end
		end else if (pick < 93) begin
			it.cmd = tshs_pkg::CMD_WRITE;
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				it.ticks = 8'($urandom_range(0, 3));
			end else if (pick < 9) begin
				it.ticks = 8'($urandom_range(0, 20));
			end
		end else begin
			it.cmd = CMD_UNUSED;
		end
		return it;
	endfunction

	// extremes of the fields and each corner of start, stop and table writes
	task automatic test_directed_cases();
		// start straight out of reset, where the phase is still zero
		send_item(make_item(tshs_pkg::CMD_START, SEL_LEFT, 32'd3, 1'b1, 4'd0, 8'd0));
		repeat (3) send_item(make_item(tshs_pkg::CMD_TICK, SEL_LEFT, '0, 1'b0, 4'd0, 8'd0));
		send_item(make_item(tshs_pkg::CMD_WRITE, SEL_RIGHT, '0, 1'b0, 4'd0, 8'd0));
		send_item(make_item(tshs_pkg::CMD_WRITE, SEL_RIGHT, '0, 1'b0, 4'd9, 8'd2));
		send_item(make_item(tshs_pkg::CMD_WRITE, SEL_RIGHT, '0, 1'b0, 4'd10, 8'd255));
		send_item(make_item(tshs_pkg::CMD_WRITE, SEL_RIGHT, '0, 1'b0, 4'd15, 8'd255));
		send_item(make_item(tshs_pkg::CMD_WRITE, SEL_NONE, '0, 1'b0, 4'd1, 8'd7));
		send_item(make_item(tshs_pkg::CMD_WRITE, SEL_GRIP, '0, 1'b0, 4'd1, 8'd255));
		send_item(make_item(tshs_pkg::CMD_START, SEL_RIGHT, 32'hFFFF_FFFF, 1'b0, 4'd0, 8'd0));
		send_item(make_item(tshs_pkg::CMD_START, SEL_GRIP, 32'd1, 1'b1, 4'd0, 8'd0));
		send_item(make_item(tshs_pkg::CMD_START, SEL_LEFT, 32'd0, 1'b0, 4'd0, 8'd0));
		send_item(make_item(tshs_pkg::CMD_START, SEL_NONE, 32'd5, 1'b1, 4'd0, 8'd0));
		send_item(make_item(CMD_UNUSED, SEL_LEFT, 32'hA5A5_5A5A, 1'b1, 4'd9, 8'd255));
		repeat (7) send_item(make_item(tshs_pkg::CMD_TICK, SEL_LEFT, '0, 1'b0, 4'd0, 8'd0));
		send_item(make_item(tshs_pkg::CMD_START, SEL_GRIP, 32'd4, 1'b0, 4'd0, 8'd0));
		repeat (2) send_item(make_item(tshs_pkg::CMD_TICK, SEL_LEFT, '0, 1'b0, 4'd0, 8'd0));
		wait_drained();
	endtask

	// ir enable toggles the packed bit and the changed flag on the next tick
	task automatic test_ir_enable_toggle();
		set_ir_enable(1'b1);
		repeat (2) send_item(make_item(tshs_pkg::CMD_TICK, SEL_LEFT, '0, 1'b0, 4'd0, 8'd0));
		wait_drained();
		set_ir_enable(1'b0);
		repeat (2) send_item(make_item(tshs_pkg::CMD_TICK, SEL_LEFT, '0, 1'b0, 4'd0, 8'd0));
		wait_drained();
	endtask

	// mixed move programs under changing ir setting, with and without backpressure
	task automatic test_random_traffic();
		for (int ph = 0; ph < 5; ph++) begin
			wait_drained();
			set_ir_enable(ph == 4 ? 1'($urandom_range(0, 1)) : ((ph % 2) == 0));
			tx_gaps_on   = (ph != 1) && (ph != 3);
			rx_stalls_on = (ph != 2) && (ph != 3);
			for (int i = 0; i < 300; i++) begin
				if (ph == 2 && i == 150) begin
					wait_drained();
				end
				send_item(random_item());
			end
		end
		wait_drained();
	endtask

	initial begin
		clk          = 1'b0;
		cycles       = 0;
		errors       = 0;
		rx_hold      = 0;
		tx_gaps_on   = 1'b1;
		rx_stalls_on = 1'b1;
		clear_scheduler_state();
		arst_n     <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		item_valid <= 1'b0;
		cmd        <= tshs_pkg::CMD_TICK;
		motor_sel  <= SEL_LEFT;
		step_total <= '0;
		clockwise  <= 1'b0;
		table_slot <= '0;
		wait_ticks <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_ir_enable_toggle();
		test_random_traffic();

		wait_drained();
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire

FILE: filelist.f
hw/rtl/tshs_pkg.sv
hw/rtl/tshs_motor.sv
hw/rtl/three_stepper_halfstep_scheduler.sv
tb/three_stepper_halfstep_scheduler_test.sv
